>>> hdl/pvct_pkg.sv
// Shared types, constants and helpers for the polygon vertex containment test.
package pvct_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 16;
    localparam int MIN_OWN      = 3;
    localparam int HIT_W        = 4;

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DET_W  = PROD_W + 1;

    localparam logic [1:0] REQ_LOAD_OWN   = 2'd0;
    localparam logic [1:0] REQ_LOAD_OTHER = 2'd1;
    localparam logic [1:0] REQ_RUN        = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } vertex_t;

    // one foreign vertex, or the reference own vertex, marching down the cell row
    typedef struct packed {
        logic                    valid;
        logic                    is_ref;
        logic [IDX_W-1:0]        idx;
        vertex_t                 v;
        logic signed [SUM_W-1:0] esum;
        logic signed [1:0]       spoke_o;
        logic signed [1:0]       edge_o;
        logic                    fan_hit;
    } chain_tok_t;

    // run-wide settings broadcast to every cell
    typedef struct packed {
        logic [CNT_W-1:0]  n;
        logic signed [1:0] ref_sign;
    } cell_ctl_t;

    function automatic logic signed [DIFF_W-1:0] coord_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [DIFF_W-1:0] ae;
        logic signed [DIFF_W-1:0] be;
        ae = {a[COORD_BITS-1], a};
        be = {b[COORD_BITS-1], b};
        return ae - be;
    endfunction

    function automatic logic signed [1:0] orient_sign(
        input logic signed [PROD_W-1:0] p,
        input logic signed [PROD_W-1:0] q
    );
        logic signed [DET_W-1:0] d;
        d = {p[PROD_W-1], p} - {q[PROD_W-1], q};
        if (d == '0)
            return 2'sd0;
        else if (d[DET_W-1])
            return -2'sd1;
        else
            return 2'sd1;
    endfunction

endpackage

>>> hdl/polygon_vertex_containment_test_top.sv
// Top level: request decode, foreign vertex store, run sequencer and the cell row.
// Loads never stall the input.
// A run raises out_valid after all other vertices have passed through the cell row;
// with fewer than 3 own vertices or no other vertices it skips the row and answers directly.
// One run at a time: in_stall drops as the result is loaded, which waits on a held result.
// Async active-low reset clears control, test_mode and the output; vertex stores are not cleared.
module polygon_vertex_containment_test_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic [3:0]                          vertex_index,
    input  logic signed [15:0]                  coord_x,
    input  logic signed [15:0]                  coord_y,
    input  logic [4:0]                          own_count,
    input  logic [4:0]                          other_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                contact,
    output logic [pvct_pkg::HIT_W-1:0]          hit_vertex,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data
);

    localparam int MAXV = pvct_pkg::MAX_VERTICES;

    typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

    state_t                       state_reg;
    logic                         test_mode_reg;
    logic [pvct_pkg::CNT_W-1:0]   n_reg, m_reg, inj_cnt_reg, out_cnt_reg;
    logic                         inj_ref_reg, found_reg;
    logic [pvct_pkg::IDX_W-1:0]   hit_reg;
    logic signed [1:0]            ref_reg;
    pvct_pkg::chain_tok_t         tok_in_reg, inj_tok;
    logic                         out_valid_reg, contact_reg;
    logic [pvct_pkg::HIT_W-1:0]   hit_vertex_reg;

    pvct_pkg::vertex_t            other_reg [MAXV];
    pvct_pkg::vertex_t            own_v [MAXV];
    pvct_pkg::chain_tok_t         tok [MAXV+1];
    pvct_pkg::cell_ctl_t          ctl;
    pvct_pkg::vertex_t            ld_v;
    logic [MAXV-1:0]              ld_en;

    logic                         accept, run_acc, load_own, load_other;
    logic [pvct_pkg::CNT_W-1:0]   n_sat, m_sat;
    pvct_pkg::chain_tok_t         last;
    logic                         exit_valid, vtx_hit;
    logic [pvct_pkg::SUM_W-1:0]   esum_mag, n_minus1;

    assign in_stall   = (state_reg != IDLE);
    assign accept     = in_valid && !in_stall;
    assign run_acc    = accept && (req_type == pvct_pkg::REQ_RUN);
    assign load_own   = accept && (req_type == pvct_pkg::REQ_LOAD_OWN);
    assign load_other = accept && (req_type == pvct_pkg::REQ_LOAD_OTHER);

    assign ld_v.x = signed'(coord_x[pvct_pkg::COORD_BITS-1:0]);
    assign ld_v.y = signed'(coord_y[pvct_pkg::COORD_BITS-1:0]);

    assign n_sat = (int'(own_count) > MAXV) ? pvct_pkg::CNT_W'(MAXV)
                                            : pvct_pkg::CNT_W'(own_count);
    assign m_sat = (int'(other_count) > MAXV) ? pvct_pkg::CNT_W'(MAXV)
                                              : pvct_pkg::CNT_W'(other_count);

    assign ctl.n        = n_reg;
    assign ctl.ref_sign = ref_reg;

    assign out_valid  = out_valid_reg;
    assign contact    = contact_reg;
    assign hit_vertex = hit_vertex_reg;

    // cell row
    assign tok[0] = tok_in_reg;
    for (genvar k = 0; k < MAXV; k++)
    begin : g_cell
        assign ld_en[k] = load_own && (int'(vertex_index) == k);
        pvct_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (pvct_pkg::IDX_W'(k)),
            .ld_en    (ld_en[k]),
            .ld_v     (ld_v),
            .own0     (own_v[0]),
            .own_next (own_v[(k + 1) % MAXV]),
            .ctl      (ctl),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1]),
            .own_v    (own_v[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (load_other && (int'(vertex_index) < MAXV))
            other_reg[pvct_pkg::IDX_W'(vertex_index)] <= ld_v;
    end

    // injection: reference token (own vertex 2) first, then other vertices in order
    always_comb
    begin
        inj_tok = '0;
        if (state_reg == RUN)
        begin
            if (inj_ref_reg)
            begin
                inj_tok.valid  = 1'b1;
                inj_tok.is_ref = 1'b1;
                inj_tok.v      = own_v[2];
            end
            else if (inj_cnt_reg < m_reg)
            begin
                inj_tok.valid = 1'b1;
                inj_tok.idx   = inj_cnt_reg[pvct_pkg::IDX_W-1:0];
                inj_tok.v     = other_reg[inj_cnt_reg[pvct_pkg::IDX_W-1:0]];
            end
        end
    end

    assign last       = tok[MAXV];
    assign exit_valid = last.valid && !last.is_ref;
    assign esum_mag   = last.esum[pvct_pkg::SUM_W-1] ? -last.esum : last.esum;
    assign n_minus1   = pvct_pkg::SUM_W'(n_reg) - pvct_pkg::SUM_W'(1);
    assign vtx_hit    = test_mode_reg ? last.fan_hit : (esum_mag >= n_minus1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            test_mode_reg    <= 1'b0;
            tok_in_reg.valid <= 1'b0;
            out_valid_reg    <= 1'b0;
            contact_reg      <= 1'b0;
            hit_vertex_reg   <= '0;
            inj_ref_reg      <= 1'b0;
            found_reg        <= 1'b0;
            n_reg            <= '0;
            m_reg            <= '0;
            inj_cnt_reg      <= '0;
            out_cnt_reg      <= '0;
            hit_reg          <= '0;
            ref_reg          <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                test_mode_reg <= cfg_wr_data;

            tok_in_reg <= inj_tok;

            // fan reference sign is the spoke of cell 1 against own vertex 2
            if (tok[2].valid && tok[2].is_ref)
                ref_reg <= tok[2].spoke_o;

            // DONE reloads the output itself when the held result leaves
            if (out_valid_reg && !out_stall && (state_reg != DONE))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                IDLE:
                begin
                    if (run_acc)
                    begin
                        n_reg       <= n_sat;
                        m_reg       <= m_sat;
                        inj_ref_reg <= 1'b1;
                        inj_cnt_reg <= '0;
                        out_cnt_reg <= '0;
                        found_reg   <= 1'b0;
                        hit_reg     <= '0;
                        if ((n_sat < pvct_pkg::CNT_W'(pvct_pkg::MIN_OWN)) || (m_sat == '0))
                            state_reg <= DONE;
                        else
                            state_reg <= RUN;
                    end
                end
                RUN:
                begin
                    if (inj_ref_reg)
                        inj_ref_reg <= 1'b0;
                    else if (inj_cnt_reg < m_reg)
                        inj_cnt_reg <= inj_cnt_reg + pvct_pkg::CNT_W'(1);

                    if (exit_valid)
                    begin
                        out_cnt_reg <= out_cnt_reg + pvct_pkg::CNT_W'(1);
                        if (vtx_hit && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            hit_reg   <= last.idx;
                        end
                        if (out_cnt_reg == m_reg - pvct_pkg::CNT_W'(1))
                            state_reg <= DONE;
                    end
                end
                DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        contact_reg    <= found_reg;
                        hit_vertex_reg <= pvct_pkg::HIT_W'(hit_reg);
                        state_reg      <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/pvct_cell.sv
// One cell of the row: holds an own vertex, scores its edge and spoke against a passing vertex.
module pvct_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pvct_pkg::IDX_W-1:0]   cell_idx,
    input  logic                         ld_en,
    input  pvct_pkg::vertex_t            ld_v,
    input  pvct_pkg::vertex_t            own0,
    input  pvct_pkg::vertex_t            own_next,
    input  pvct_pkg::cell_ctl_t          ctl,
    input  pvct_pkg::chain_tok_t         tok_in,
    output pvct_pkg::chain_tok_t         tok_out,
    output pvct_pkg::vertex_t            own_v
);

    pvct_pkg::vertex_t    vert_reg;
    pvct_pkg::chain_tok_t a_tok_reg;
    pvct_pkg::chain_tok_t b_tok_reg;
    pvct_pkg::chain_tok_t b_tok_next;

    logic signed [pvct_pkg::PROD_W-1:0] pe1_reg, pe2_reg, ps1_reg, ps2_reg;

    pvct_pkg::vertex_t                  nxt;
    logic [pvct_pkg::CNT_W-1:0]         k;
    logic signed [1:0]                  e_k, s_k;
    logic signed [3:0]                  tri_sum, ref3;
    logic                               edge_on, tri_on;

    assign own_v   = vert_reg;
    assign tok_out = b_tok_reg;
    assign k       = pvct_pkg::CNT_W'(cell_idx);

    // last active edge wraps back to vertex 0
    assign nxt = (k == ctl.n - pvct_pkg::CNT_W'(1)) ? own0 : own_next;

    always_ff @(posedge clk)
    begin
        if (ld_en)
            vert_reg <= ld_v;
    end

    // stage A: differences and products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tok_reg.valid <= 1'b0;
        end
        else
        begin
            a_tok_reg <= tok_in;
            pe1_reg <= pvct_pkg::coord_diff(nxt.x, vert_reg.x)
                     * pvct_pkg::coord_diff(tok_in.v.y, vert_reg.y);
            pe2_reg <= pvct_pkg::coord_diff(nxt.y, vert_reg.y)
                     * pvct_pkg::coord_diff(tok_in.v.x, vert_reg.x);
            ps1_reg <= pvct_pkg::coord_diff(vert_reg.x, own0.x)
                     * pvct_pkg::coord_diff(tok_in.v.y, own0.y);
            ps2_reg <= pvct_pkg::coord_diff(vert_reg.y, own0.y)
                     * pvct_pkg::coord_diff(tok_in.v.x, own0.x);
        end
    end

    // stage B: signs, edge count, fan triangle closing at this cell
    always_comb
    begin
        e_k     = pvct_pkg::orient_sign(pe1_reg, pe2_reg);
        s_k     = pvct_pkg::orient_sign(ps1_reg, ps2_reg);
        edge_on = (k < ctl.n);
        tri_on  = (k >= pvct_pkg::CNT_W'(2)) && (k < ctl.n);
        // triangle (0, k-1, k): spoke(k-1) + edge(k-1) - spoke(k)
        tri_sum = {{2{a_tok_reg.spoke_o[1]}}, a_tok_reg.spoke_o}
                + {{2{a_tok_reg.edge_o[1]}}, a_tok_reg.edge_o}
                - {{2{s_k[1]}}, s_k};
        ref3    = {{2{ctl.ref_sign[1]}}, ctl.ref_sign}
                + {{1{ctl.ref_sign[1]}}, ctl.ref_sign, 1'b0};

        b_tok_next         = a_tok_reg;
        b_tok_next.spoke_o = s_k;
        b_tok_next.edge_o  = e_k;
        if (edge_on)
            b_tok_next.esum = a_tok_reg.esum + {{(pvct_pkg::SUM_W-2){e_k[1]}}, e_k};
        if (tri_on && (tri_sum == ref3))
            b_tok_next.fan_hit = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_tok_reg.valid <= 1'b0;
        end
        else
        begin
            b_tok_reg <= b_tok_next;
        end
    end

endmodule

>>> hdl/pvct_checker.sv
// Port-level checks for the containment test block, bound to the top level.
module pvct_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [1:0]                    req_type,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          contact,
    input logic [pvct_pkg::HIT_W-1:0]    hit_vertex
);

    // a result held under stall does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(contact) && $stable(hit_vertex))
        else $error("result changed while stalled");

    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !contact |-> hit_vertex == '0)
        else $error("hit index set without contact");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == pvct_pkg::REQ_RUN) |=> in_stall)
        else $error("run transaction did not make the block busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type != pvct_pkg::REQ_RUN) |=> !in_stall)
        else $error("load transaction stalled the input");

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared outside a run");

endmodule

bind polygon_vertex_containment_test_top pvct_checker u_pvct_checker (.*);

>>> bench/tb_polygon_vertex_containment_test_top.sv
// Self-checking bench for the polygon vertex containment block: directed table, then random runs.
`timescale 1ns / 1ps

module tb_polygon_vertex_containment_test_top;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam bit MODE_EDGE = 1'b0;
    localparam bit MODE_FAN  = 1'b1;

    localparam logic [15:0] C_MIN = 16'h8000;
    localparam logic [15:0] C_MAX = 16'h7fff;

    localparam int ITEMS       = 1850;
    localparam int PHASE_ITEMS = 300;
    localparam int SETTLE      = 2 * pvct_pkg::MAX_VERTICES + 2 + pvct_pkg::MAX_VERTICES;
    localparam int TAIL        = 60;
    localparam int HOLD_CYCLES = 600;
    localparam int LIMIT       = 1000000;
    localparam real TWO_PI     = 6.283185307179586;

    typedef struct packed {
        logic                       contact;
        logic [pvct_pkg::HIT_W-1:0] hit;
    } report_t;

    typedef struct packed {
        bit          mode;
        logic [1:0]  rq;
        logic [3:0]  idx;
        logic [15:0] x;
        logic [15:0] y;
        logic [4:0]  n;
        logic [4:0]  m;
        bit          typed;
        logic        tc;
        logic [3:0]  th;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        req_type;
    logic [3:0]        vertex_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [4:0]        own_count;
    logic [4:0]        other_count;
    logic              out_valid;
    logic              out_stall;
    logic              contact;
    logic [pvct_pkg::HIT_W-1:0] hit_vertex;
    logic              cfg_wr_en;
    logic              cfg_wr_data;

    // typed expectation travelling with the payload of a directed run
    bit          typed_on;
    logic        typed_contact;
    logic [3:0]  typed_hit;

    // predictor state
    bit                 fan_mode;
    logic signed [15:0] own_x [pvct_pkg::MAX_VERTICES];
    logic signed [15:0] own_y [pvct_pkg::MAX_VERTICES];
    logic signed [15:0] oth_x [pvct_pkg::MAX_VERTICES];
    logic signed [15:0] oth_y [pvct_pkg::MAX_VERTICES];
    report_t            pending_reports [$];

    // scratch polygon for the random sequences
    logic signed [15:0] shape_x [pvct_pkg::MAX_VERTICES];
    logic signed [15:0] shape_y [pvct_pkg::MAX_VERTICES];

    stim_row_t rows [$];
    bit        cur_mode;
    bit        hold_req;
    int        no_gap_left;
    int        items_sent;
    int        runs_seen;
    int        reports_checked;
    int        contacts_seen;
    int        errors;
    int        cycle_count;

    polygon_vertex_containment_test_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .own_count    (own_count),
        .other_count  (other_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .contact      (contact),
        .hit_vertex   (hit_vertex),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic int turn_dir(input longint ax, input longint ay, input longint bx,
                                    input longint by, input longint cx, input longint cy);
        longint det;
        det = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        if (det > 0)
            return 1;
        else if (det < 0)
            return -1;
        return 0;
    endfunction

    function automatic bit inside_by_edges(input longint vx, input longint vy, input int n);
        int sum;
        int j;
        int k;
        sum = 0;
        for (j = 0; j < n; j++)
        begin
            k = (j + 1 == n) ? 0 : j + 1;
            sum += turn_dir(own_x[j], own_y[j], own_x[k], own_y[k], vx, vy);
        end
        if (sum < 0)
            sum = -sum;
        return sum >= n - 1;
    endfunction

    function automatic bit inside_by_fan(input longint vx, input longint vy, input int n);
        int ref_dir;
        int s;
        int j;
        ref_dir = turn_dir(own_x[0], own_y[0], own_x[1], own_y[1], own_x[2], own_y[2]);
        for (j = 1; j + 1 < n; j++)
        begin
            s = turn_dir(own_x[0], own_y[0], own_x[j], own_y[j], vx, vy)
              + turn_dir(own_x[j], own_y[j], own_x[j+1], own_y[j+1], vx, vy)
              + turn_dir(own_x[j+1], own_y[j+1], own_x[0], own_y[0], vx, vy);
            // degenerate first triangle gives ref 0, same rule
            if (s == 3 * ref_dir)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic report_t run_outcome(input logic [4:0] oc, input logic [4:0] mc);
        report_t res;
        int      n;
        int      m;
        int      i;
        bit      hit;
        res = '0;
        n = (oc > pvct_pkg::MAX_VERTICES) ? pvct_pkg::MAX_VERTICES : oc;
        m = (mc > pvct_pkg::MAX_VERTICES) ? pvct_pkg::MAX_VERTICES : mc;
        if (n >= pvct_pkg::MIN_OWN)
        begin
            for (i = 0; i < m && !res.contact; i++)
            begin
                hit = (fan_mode == MODE_FAN) ? inside_by_fan(oth_x[i], oth_y[i], n)
                                             : inside_by_edges(oth_x[i], oth_y[i], n);
                if (hit)
                begin
                    res.contact = 1'b1;
                    res.hit     = 4'(i);
                end
            end
        end
        return res;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : monitor
        report_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                fan_mode = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                case (req_type)
                    pvct_pkg::REQ_LOAD_OWN:
                    begin
                        own_x[vertex_index] = coord_x;
                        own_y[vertex_index] = coord_y;
                    end
                    pvct_pkg::REQ_LOAD_OTHER:
                    begin
                        oth_x[vertex_index] = coord_x;
                        oth_y[vertex_index] = coord_y;
                    end
                    pvct_pkg::REQ_RUN:
                    begin
                        if (typed_on)
                        begin
                            want.contact = typed_contact;
                            want.hit     = typed_hit;
                        end
                        else
                            want = run_outcome(own_count, other_count);
                        pending_reports = {pending_reports, want};
                        runs_seen++;
                    end
                    default:
                        ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                    flag_error($sformatf("report with none pending: contact %0d hit %0d",
                                         contact, hit_vertex));
                else
                begin
                    want = pending_reports.pop_front();
                    reports_checked++;
                    if (contact === 1'b1)
                        contacts_seen++;
                    if (contact !== want.contact || hit_vertex !== want.hit)
                        flag_error($sformatf("contact exp %0d got %0d, hit_vertex exp %0d got %0d",
                                             want.contact, contact, want.hit, hit_vertex));
                end
            end
        end
    end

    // ---------------- receiver stall ----------------

    initial
    begin : rx_stall
        int left;
        int r;
        out_stall = 1'b0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // long hold-off so runs back up into the input
                hold_req = 1'b0;
                out_stall <= 1'b1;
                left = HOLD_CYCLES;
            end
            else if (left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    out_stall <= 1'b0;
                    left = $urandom_range(1, 30);
                end
                else if (r < 60)
                begin
                    out_stall <= 1'b0;
                    left = $urandom_range(100, 300);
                end
                else if (r < 92)
                begin
                    out_stall <= 1'b1;
                    left = $urandom_range(1, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    left = $urandom_range(15, 60);
                end
            end
            if (left > 0)
                left--;
        end
    end

    // ---------------- sender ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic real frac();
        return $urandom_range(0, 10000) / 10000.0;
    endfunction

    function automatic logic [15:0] to_coord(input longint v);
        if (v > 32767)
            return C_MAX;
        if (v < -32768)
            return C_MIN;
        return v[15:0];
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input logic [1:0] rq, input logic [3:0] idx, input logic [15:0] x,
                            input logic [15:0] y, input logic [4:0] n, input logic [4:0] m,
                            input bit typed, input logic tc, input logic [3:0] th);
        int gap;
        if (no_gap_left > 0)
        begin
            gap = 0;
            no_gap_left--;
        end
        else
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= rq;
        vertex_index  <= idx;
        coord_x       <= x;
        coord_y       <= y;
        own_count     <= n;
        other_count   <= m;
        typed_on      <= typed;
        typed_contact <= tc;
        typed_hit     <= th;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (rq != REQ_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic set_mode(input bit md);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        // loads leave no report; let any trailing work finish
        repeat (SETTLE) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= md;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_mode = md;
    endtask

    task automatic put_row(input bit md, input logic [1:0] rq, input logic [3:0] idx,
                           input logic [15:0] x, input logic [15:0] y, input logic [4:0] n,
                           input logic [4:0] m, input bit typed, input logic tc,
                           input logic [3:0] th);
        stim_row_t row;
        row = '{md, rq, idx, x, y, n, m, typed, tc, th};
        rows = {rows, row};
    endtask

    // own polygon around a center, foreign vertices near it, then one or two runs
    task automatic send_sequence();
        int     n;
        int     m;
        int     kind;
        int     k;
        int     j;
        int     pick;
        real    r;
        real    cx;
        real    cy;
        real    base;
        real    step;
        real    ang;
        real    rad;
        real    dir;
        bit     concave;
        longint px;
        longint py;
        logic [4:0] nc;
        logic [4:0] mc;

        kind = $urandom_range(0, 9);
        if (kind < 3)
        begin
            // tiny shapes: rounding makes collinear and degenerate cases common
            r  = $urandom_range(1, 6);
            cx = int'($urandom_range(0, 40)) - 20;
            cy = int'($urandom_range(0, 40)) - 20;
        end
        else if (kind < 8)
        begin
            r  = $urandom_range(50, 3000);
            cx = int'($urandom_range(0, 40000)) - 20000;
            cy = int'($urandom_range(0, 40000)) - 20000;
        end
        else
        begin
            // clipped against the coordinate range
            r  = $urandom_range(30000, 50000);
            cx = 0.0;
            cy = 0.0;
        end

        pick = $urandom_range(0, 9);
        if (pick < 6)
            n = $urandom_range(3, 6);
        else if (pick < 9)
            n = $urandom_range(7, 12);
        else
            n = $urandom_range(13, 16);

        concave = ($urandom_range(0, 2) == 0);
        dir  = ($urandom_range(0, 1) == 1) ? 1.0 : -1.0;
        base = frac() * TWO_PI;
        step = TWO_PI / n;
        for (k = 0; k < n; k++)
        begin
            ang = base + dir * (k * step + (frac() - 0.5) * 0.6 * step);
            rad = concave ? r * (0.25 + 0.75 * frac()) : r;
            shape_x[k] = to_coord($rtoi(cx + rad * $cos(ang)));
            shape_y[k] = to_coord($rtoi(cy + rad * $sin(ang)));
            send_req(pvct_pkg::REQ_LOAD_OWN, 4'(k), shape_x[k], shape_y[k], 5'($urandom()),
                     5'($urandom()), 1'b0, 1'b0, 4'd0);
        end

        m = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 5) : $urandom_range(6, 16);
        for (k = 0; k < m; k++)
        begin
            pick = $urandom_range(0, 9);
            j = $urandom_range(0, n - 1);
            if (pick < 2)
            begin
                px = shape_x[j];
                py = shape_y[j];
            end
            else if (pick < 4)
            begin
                px = (longint'(shape_x[j]) + longint'(shape_x[(j + 1) % n])) / 2;
                py = (longint'(shape_y[j]) + longint'(shape_y[(j + 1) % n])) / 2;
            end
            else
            begin
                px = $rtoi(cx + (frac() * 2.6 - 1.3) * r);
                py = $rtoi(cy + (frac() * 2.6 - 1.3) * r);
            end
            send_req(pvct_pkg::REQ_LOAD_OTHER, 4'(k), to_coord(px), to_coord(py),
                     5'($urandom()), 5'($urandom()), 1'b0, 1'b0, 4'd0);
        end

        nc = 5'(n);
        if (n == pvct_pkg::MAX_VERTICES && $urandom_range(0, 1) == 1)
            nc = 5'($urandom_range(16, 31));
        mc = 5'(m);
        if ($urandom_range(0, 9) == 0)
            mc = 5'($urandom_range(0, 31));
        send_req(pvct_pkg::REQ_RUN, 4'($urandom()), 16'($urandom()), 16'($urandom()), nc, mc,
                 1'b0, 1'b0, 4'd0);
        if ($urandom_range(0, 3) == 0)
            send_req(pvct_pkg::REQ_RUN, 4'($urandom()), 16'($urandom()), 16'($urandom()), nc,
                     5'($urandom_range(1, m)), 1'b0, 1'b0, 4'd0);
    endtask

    task automatic send_noise();
        int r;
        logic [15:0] x;
        logic [15:0] y;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                x = 16'($urandom());
                y = 16'($urandom());
            end
            else
            begin
                x = 16'(int'($urandom_range(0, 8)) - 4);
                y = 16'(int'($urandom_range(0, 8)) - 4);
            end
            send_req(($urandom_range(0, 1) == 1) ? pvct_pkg::REQ_LOAD_OTHER
                                                 : pvct_pkg::REQ_LOAD_OWN,
                     4'($urandom()), x, y, 5'($urandom()), 5'($urandom()), 1'b0, 1'b0, 4'd0);
        end
        else if (r < 55)
            send_req(REQ_UNUSED, 4'($urandom()), 16'($urandom()), 16'($urandom()),
                     5'($urandom()), 5'($urandom()), 1'b0, 1'b0, 4'd0);
        else if (r < 65)
            send_req(pvct_pkg::REQ_RUN, 4'($urandom()), 16'($urandom()), 16'($urandom()),
                     5'($urandom_range(0, 2)), 5'($urandom()), 1'b0, 1'b0, 4'd0);
        else
            send_req(pvct_pkg::REQ_RUN, 4'($urandom()), 16'($urandom()), 16'($urandom()),
                     5'($urandom()), 5'($urandom()), 1'b0, 1'b0, 4'd0);
    endtask

    initial
    begin : main
        int        i;
        int        next_switch;
        bit        pressure_done;
        stim_row_t row;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = pvct_pkg::REQ_LOAD_OWN;
        vertex_index  = '0;
        coord_x       = '0;
        coord_y       = '0;
        own_count     = '0;
        other_count   = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        typed_on      = 1'b0;
        typed_contact = 1'b0;
        typed_hit     = '0;
        fan_mode      = MODE_EDGE;
        cur_mode      = MODE_EDGE;
        hold_req      = 1'b0;
        no_gap_left   = 0;
        items_sent    = 0;
        runs_seen     = 0;
        reports_checked = 0;
        contacts_seen = 0;
        errors        = 0;
        cycle_count   = 0;
        pressure_done = 1'b0;
        for (i = 0; i < pvct_pkg::MAX_VERTICES; i++)
        begin
            own_x[i] = '0;
            own_y[i] = '0;
            oth_x[i] = '0;
            oth_y[i] = '0;
        end

        // directed table: only slots 0..3 own and 0..2 other are ever read here
        put_row(MODE_EDGE, pvct_pkg::REQ_RUN, 4'd0, 16'd0, 16'd0, 5'd0, 5'd0, 1, 1'b0, 4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_RUN, 4'd15, C_MAX, C_MIN, 5'd2, 5'd5, 1, 1'b0, 4'd0);
        put_row(MODE_EDGE, REQ_UNUSED, 4'd7, 16'h1234, 16'h5678, 5'd3, 5'd3, 0, 1'b0, 4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_LOAD_OWN, 4'd0, C_MIN, C_MIN, 5'd0, 5'd0, 0, 1'b0, 4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_LOAD_OWN, 4'd1, C_MAX, C_MIN, 5'd0, 5'd0, 0, 1'b0, 4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_LOAD_OWN, 4'd2, C_MAX, C_MAX, 5'd0, 5'd0, 0, 1'b0, 4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_LOAD_OWN, 4'd3, C_MIN, C_MAX, 5'd31, 5'd31, 0, 1'b0,
                4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_LOAD_OTHER, 4'd0, C_MIN, C_MIN, 5'd0, 5'd0, 0, 1'b0,
                4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_LOAD_OTHER, 4'd1, 16'd0, 16'd0, 5'd0, 5'd0, 0, 1'b0,
                4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_LOAD_OTHER, 4'd2, C_MAX, 16'd0, 5'd0, 5'd0, 0, 1'b0,
                4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_LOAD_OTHER, 4'd15, C_MAX, C_MAX, 5'd0, 5'd0, 0, 1'b0,
                4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_RUN, 4'd0, 16'd0, 16'd0, 5'd4, 5'd3, 0, 1'b0, 4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_RUN, 4'd0, 16'd0, 16'd0, 5'd3, 5'd1, 0, 1'b0, 4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_RUN, 4'd0, 16'd0, 16'd0, 5'd4, 5'd0, 1, 1'b0, 4'd0);
        put_row(MODE_FAN, pvct_pkg::REQ_RUN, 4'd0, 16'd0, 16'd0, 5'd4, 5'd3, 0, 1'b0, 4'd0);
        // first fan triangle made collinear
        put_row(MODE_FAN, pvct_pkg::REQ_LOAD_OWN, 4'd2, 16'd0, C_MIN, 5'd0, 5'd0, 0, 1'b0, 4'd0);
        put_row(MODE_FAN, pvct_pkg::REQ_RUN, 4'd0, 16'd0, 16'd0, 5'd3, 5'd3, 0, 1'b0, 4'd0);
        put_row(MODE_FAN, pvct_pkg::REQ_RUN, 4'd0, 16'd0, 16'd0, 5'd4, 5'd2, 0, 1'b0, 4'd0);
        put_row(MODE_FAN, pvct_pkg::REQ_RUN, 4'd0, 16'd0, 16'd0, 5'd1, 5'd31, 1, 1'b0, 4'd0);
        put_row(MODE_EDGE, pvct_pkg::REQ_RUN, 4'd0, 16'd0, 16'd0, 5'd2, 5'd31, 1, 1'b0, 4'd0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.mode != cur_mode)
                set_mode(row.mode);
            send_req(row.rq, row.idx, row.x, row.y, row.n, row.m, row.typed, row.tc, row.th);
        end

        // every slot written once, so any count is legal from here on
        for (i = 0; i < pvct_pkg::MAX_VERTICES; i++)
        begin
            send_req(pvct_pkg::REQ_LOAD_OWN, 4'(i), 16'($urandom()), 16'($urandom()),
                     5'($urandom()), 5'($urandom()), 1'b0, 1'b0, 4'd0);
            send_req(pvct_pkg::REQ_LOAD_OTHER, 4'(i), 16'($urandom()), 16'($urandom()),
                     5'($urandom()), 5'($urandom()), 1'b0, 1'b0, 4'd0);
        end

        next_switch = items_sent + PHASE_ITEMS;
        while (items_sent < ITEMS)
        begin
            if (items_sent >= next_switch)
            begin
                set_mode(!cur_mode);
                next_switch = items_sent + PHASE_ITEMS;
            end
            if (!pressure_done && items_sent >= ITEMS / 2)
            begin
                hold_req      = 1'b1;
                no_gap_left   = 80;
                pressure_done = 1'b1;
            end
            else if (no_gap_left == 0 && $urandom_range(0, 49) == 0)
                no_gap_left = 30;
            if ($urandom_range(0, 99) < 70)
                send_sequence();
            else
                send_noise();
        end

        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (TAIL) @(negedge clk);

        $display("Sent %0d transactions with %0d runs; %0d reports checked, %0d with contact.",
                 items_sent, runs_seen, reports_checked, contacts_seen);
        $display("Edge and fan modes alternated; one %0d-cycle receiver hold-off; %0d mismatches.",
                 HOLD_CYCLES, errors);
        if (errors == 0 && pending_reports.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
